/* sv/clb_pkg.sv */
// Shared types and constants for the cell list binning unit.
// Used by clb_axis_unit and cell_list_binning_unit; depends on nothing.
package clb_pkg;

	// Grid and storage geometry.
	localparam int CELLS_PER_AXIS   = 16;
	localparam int SLOTS_PER_CELL   = 32;
	localparam int FRAC_BITS        = 16;
	localparam int CELL_W           = $clog2(CELLS_PER_AXIS);
	localparam int SLOT_W           = $clog2(SLOTS_PER_CELL);
	localparam int CELL_ID_W        = 3 * CELL_W;
	localparam int NUM_CELLS        = 2 ** CELL_ID_W;
	localparam int SLOT_ADDR_W      = CELL_ID_W + SLOT_W;
	localparam int NUM_SLOT_ENTRIES = 2 ** SLOT_ADDR_W;

	// Field widths.
	localparam int FRAC_W  = 19;
	localparam int NCELL_W = 5;
	localparam int COUNT_W = 6;
	localparam int LABEL_W = 16;
	localparam int CFG_W   = 6;

	// Arithmetic widths of the axis unit.
	localparam int PROD_W = FRAC_W + NCELL_W + 1;
	localparam int QUO_W  = PROD_W - FRAC_BITS;
	localparam int REM_W  = QUO_W + NCELL_W - 1;
	localparam int DVS_W  = REM_W + NCELL_W - 1;
	localparam int STEP_W = $clog2(REM_W);

	// Action codes carried in the input tuser; bit 1 set means clear.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam int         ACT_CLEAR_BIT = 1;

	// Result status codes carried in the output tuser.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_CLEARED = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_CELLS_A = 2'd0;
	localparam logic [1:0] REG_CELLS_B = 2'd1;
	localparam logic [1:0] REG_CELLS_C = 2'd2;
	localparam logic [1:0] REG_SLOTS   = 2'd3;

	// Input tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic [5:0]                pad;
		logic [SLOT_W-1:0]         read_slot;
		logic [CELL_W-1:0]         read_cell_c;
		logic [CELL_W-1:0]         read_cell_b;
		logic [CELL_W-1:0]         read_cell_a;
		logic signed [FRAC_W-1:0]  frac_c;
		logic signed [FRAC_W-1:0]  frac_b;
		logic signed [FRAC_W-1:0]  frac_a;
		logic [LABEL_W-1:0]        atom_label;
	} clb_in_t;

	// Output tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic                pad;
		logic [COUNT_W-1:0]  cell_count;
		logic [LABEL_W-1:0]  label_out;
		logic [SLOT_W-1:0]   slot;
		logic [CELL_W-1:0]   cell_c;
		logic [CELL_W-1:0]   cell_b;
		logic [CELL_W-1:0]   cell_a;
	} clb_out_t;

	// Request to the axis unit.
	typedef struct packed {
		logic                     start;
		logic signed [FRAC_W-1:0] frac;
		logic [NCELL_W-1:0]       ncells;
	} clb_axis_req_t;

	// Response from the axis unit.
	typedef struct packed {
		logic              done;
		logic [CELL_W-1:0] idx;
	} clb_axis_rsp_t;

endpackage

/* sv/clb_axis_unit.sv */
// Shared axis binning unit: floor(frac * n) wrapped into [0, n).
// One multiply, then a restoring remainder one bit per cycle. Depends on clb_pkg.
module clb_axis_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  clb_pkg::clb_axis_req_t req,
	output clb_pkg::clb_axis_rsp_t rsp
);

	typedef enum logic [1:0] {
		U_IDLE,
		U_OFFS,
		U_DIV,
		U_DONE
	} ustate_t;

	ustate_t                              state_q;
	logic signed [clb_pkg::PROD_W-1:0]    prod_q;
	logic [clb_pkg::NCELL_W-1:0]          n_q;
	logic [clb_pkg::REM_W-1:0]            rem_q;
	logic [clb_pkg::DVS_W-1:0]            dvs_q;
	logic [clb_pkg::STEP_W-1:0]           step_q;

	logic signed [clb_pkg::PROD_W-1:0]    prod;
	logic signed [clb_pkg::QUO_W-1:0]     quo;
	logic signed [clb_pkg::REM_W:0]       offs;
	logic                                 ge;

	// Signed product of the coordinate and the cell count.
	assign prod = $signed({{(clb_pkg::PROD_W-clb_pkg::FRAC_W){req.frac[clb_pkg::FRAC_W-1]}},
			req.frac}) * $signed({{(clb_pkg::PROD_W-clb_pkg::NCELL_W){1'b0}}, req.ncells});

	// Arithmetic shift right floors; adding a multiple of n makes it non-negative.
	assign quo  = prod_q[clb_pkg::PROD_W-1:clb_pkg::FRAC_BITS];
	assign offs = $signed({{(clb_pkg::REM_W+1-clb_pkg::QUO_W){quo[clb_pkg::QUO_W-1]}}, quo})
			+ $signed({1'b0, n_q, {(clb_pkg::QUO_W-1){1'b0}}});

	// One restoring step: compare against the shifted divisor.
	assign ge = {{(clb_pkg::DVS_W-clb_pkg::REM_W){1'b0}}, rem_q} >= dvs_q;

	assign rsp.done = (state_q == U_DONE);
	assign rsp.idx  = rem_q[clb_pkg::CELL_W-1:0];

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						prod_q  <= prod;
						n_q     <= req.ncells;
						state_q <= U_OFFS;
					end
				end
				U_OFFS: begin
					rem_q   <= offs[clb_pkg::REM_W-1:0];
					dvs_q   <= {n_q, {(clb_pkg::REM_W-1){1'b0}}};
					step_q  <= clb_pkg::STEP_W'(clb_pkg::REM_W - 1);
					state_q <= U_DIV;
				end
				U_DIV: begin
					if (ge) begin
						rem_q <= rem_q - dvs_q[clb_pkg::REM_W-1:0];
					end
					dvs_q <= dvs_q >> 1;
					if (step_q == '0) begin
						state_q <= U_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				U_DONE: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/clb_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the cell fill counts and the slot table. Depends on nothing.
module clb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/cell_list_binning_unit.sv */
// Cell list binning unit. Items arrive on the s_ side: tuser carries the action (insert, read,
// or clear when bit 1 is set) and tdata the label, three Q2.16 fractional coordinates and a read
// address. Each transfer gives exactly one result on the m_ side, with the status in tuser. One
// item is handled at a time and the input is ready only while the sequencer waits for work; a
// finished result sits in the output register, so the next item may be taken before it is
// drained. An insert is paced by the shared axis unit, which bins the three coordinates one
// after another (one multiply, an offset, and a 13-step restoring remainder). A read is paced
// by the registered reads of the count memory and then the slot memory. A clear sweeps all
// 4096 cell counts to zero, one per cycle, before its result appears; the same clearing pass
// runs after reset, and no item is accepted until it ends. Configuration writes are taken in
// any cycle.
module cell_list_binning_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [5:0]  cfg_wdata,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// From bit 0: atom_label[15:0], frac_a[18:0], frac_b[18:0], frac_c[18:0],
	// read_cell_a[3:0], read_cell_b[3:0], read_cell_c[3:0], read_slot[4:0], zero fill.
	input  logic [95:0] s_tdata,
	// action[1:0].
	input  logic [1:0]  s_tuser,
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// From bit 0: cell_a[3:0], cell_b[3:0], cell_c[3:0], slot[4:0], label_out[15:0],
	// cell_count[5:0], zero fill.
	output logic [39:0] m_tdata,
	// status[1:0].
	output logic [1:0]  m_tuser
);

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_LAUNCH,
		ST_BIN,
		ST_FILL_RD,
		ST_DECIDE,
		ST_SLOT_WAIT,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic [clb_pkg::NCELL_W-1:0]         cells_q [3];
	logic [clb_pkg::COUNT_W-1:0]         slots_q;
	logic [clb_pkg::CELL_ID_W-1:0]       sweep_q;
	logic                                clr_item_q;
	logic                                is_insert_q;
	logic [1:0]                          axis_q;
	logic signed [clb_pkg::FRAC_W-1:0]   frac_q [3];
	logic [clb_pkg::LABEL_W-1:0]         label_q;
	logic [clb_pkg::CELL_W-1:0]          cell_q [3];
	logic [clb_pkg::SLOT_W-1:0]          res_slot_q;
	logic [clb_pkg::LABEL_W-1:0]         res_label_q;
	logic [clb_pkg::COUNT_W-1:0]         res_count_q;
	logic [1:0]                          res_status_q;
	logic                                m_tvalid_q;
	clb_pkg::clb_out_t                   m_tdata_q;
	logic [1:0]                          m_tuser_q;

	clb_pkg::clb_in_t                    in_item;
	clb_pkg::clb_axis_req_t              axis_req;
	clb_pkg::clb_axis_rsp_t              axis_rsp;
	logic [clb_pkg::CELL_ID_W-1:0]       cell_id;
	logic [clb_pkg::COUNT_W-1:0]         slot_lim;
	logic [clb_pkg::COUNT_W-1:0]         fill_rdata;
	logic                                fill_we;
	logic [clb_pkg::CELL_ID_W-1:0]       fill_waddr;
	logic [clb_pkg::COUNT_W-1:0]         fill_wdata;
	logic                                cell_full;
	logic                                slot_hit;
	logic                                slot_we;
	logic                                slot_re;
	logic [clb_pkg::SLOT_ADDR_W-1:0]     slot_waddr;
	logic [clb_pkg::SLOT_ADDR_W-1:0]     slot_raddr;
	logic [clb_pkg::LABEL_W-1:0]         slot_rdata;
	logic                                in_xfer;

	// Out-of-range cell counts act as the nearest legal value.
	function automatic logic [clb_pkg::NCELL_W-1:0] clamp_cells(
		input logic [clb_pkg::NCELL_W-1:0] r
	);
		logic [clb_pkg::NCELL_W-1:0] v;
		v = r;
		if (r == '0) begin
			v = clb_pkg::NCELL_W'(1);
		end else if (r > clb_pkg::NCELL_W'(clb_pkg::CELLS_PER_AXIS)) begin
			v = clb_pkg::NCELL_W'(clb_pkg::CELLS_PER_AXIS);
		end
		return v;
	endfunction

	assign in_item  = s_tdata;
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Per-cell slot limit, clamped to the slots that exist.
	always_comb begin
		slot_lim = slots_q;
		if (slots_q == '0) begin
			slot_lim = clb_pkg::COUNT_W'(1);
		end else if (slots_q > clb_pkg::COUNT_W'(clb_pkg::SLOTS_PER_CELL)) begin
			slot_lim = clb_pkg::COUNT_W'(clb_pkg::SLOTS_PER_CELL);
		end
	end

	// Axis unit request for the axis now being binned.
	assign axis_req.start  = (state_q == ST_LAUNCH);
	assign axis_req.frac   = frac_q[axis_q];
	assign axis_req.ncells = clamp_cells(cells_q[axis_q]);

	clb_axis_unit u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (axis_req),
		.rsp    (axis_rsp)
	);

	assign cell_id = {cell_q[0], cell_q[1], cell_q[2]};

	// Cell fill counts: written by the clearing sweep or by an insert.
	assign cell_full  = fill_rdata >= slot_lim;
	assign fill_we    = (state_q == ST_SWEEP)
			|| (state_q == ST_DECIDE && is_insert_q && !cell_full);
	assign fill_waddr = (state_q == ST_SWEEP) ? sweep_q : cell_id;
	assign fill_wdata = (state_q == ST_SWEEP) ? '0 : fill_rdata + clb_pkg::COUNT_W'(1);

	clb_ram #(
		.WIDTH (clb_pkg::COUNT_W),
		.DEPTH (clb_pkg::NUM_CELLS)
	) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (state_q == ST_FILL_RD),
		.raddr (cell_id),
		.rdata (fill_rdata)
	);

	// Slot table: labels stored per cell and slot.
	assign slot_hit   = {1'b0, res_slot_q} < fill_rdata;
	assign slot_we    = (state_q == ST_DECIDE) && is_insert_q && !cell_full;
	assign slot_re    = (state_q == ST_DECIDE) && !is_insert_q && slot_hit;
	assign slot_waddr = {cell_id, fill_rdata[clb_pkg::SLOT_W-1:0]};
	assign slot_raddr = {cell_id, res_slot_q};

	clb_ram #(
		.WIDTH (clb_pkg::LABEL_W),
		.DEPTH (clb_pkg::NUM_SLOT_ENTRIES)
	) u_slots (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (label_q),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q[0] <= clb_pkg::NCELL_W'(1);
			cells_q[1] <= clb_pkg::NCELL_W'(1);
			cells_q[2] <= clb_pkg::NCELL_W'(1);
			slots_q    <= clb_pkg::COUNT_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				clb_pkg::REG_CELLS_A: cells_q[0] <= cfg_wdata[clb_pkg::NCELL_W-1:0];
				clb_pkg::REG_CELLS_B: cells_q[1] <= cfg_wdata[clb_pkg::NCELL_W-1:0];
				clb_pkg::REG_CELLS_C: cells_q[2] <= cfg_wdata[clb_pkg::NCELL_W-1:0];
				clb_pkg::REG_SLOTS:   slots_q    <= cfg_wdata[clb_pkg::COUNT_W-1:0];
			endcase
		end
	end

	// Sequencer, result registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			sweep_q    <= '0;
			clr_item_q <= 1'b0;
			axis_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A drained output register empties unless the done state refills it.
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == {clb_pkg::CELL_ID_W{1'b1}}) begin
						if (clr_item_q) begin
							cell_q[0]    <= '0;
							cell_q[1]    <= '0;
							cell_q[2]    <= '0;
							res_slot_q   <= '0;
							res_label_q  <= '0;
							res_count_q  <= '0;
							res_status_q <= clb_pkg::STAT_CLEARED;
							state_q      <= ST_DONE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						label_q     <= in_item.atom_label;
						frac_q[0]   <= in_item.frac_a;
						frac_q[1]   <= in_item.frac_b;
						frac_q[2]   <= in_item.frac_c;
						res_slot_q  <= in_item.read_slot;
						is_insert_q <= (s_tuser == clb_pkg::ACT_INSERT);
						axis_q      <= '0;
						if (s_tuser[clb_pkg::ACT_CLEAR_BIT]) begin
							clr_item_q <= 1'b1;
							sweep_q    <= '0;
							state_q    <= ST_SWEEP;
						end else if (s_tuser == clb_pkg::ACT_INSERT) begin
							state_q <= ST_LAUNCH;
						end else begin
							cell_q[0] <= in_item.read_cell_a;
							cell_q[1] <= in_item.read_cell_b;
							cell_q[2] <= in_item.read_cell_c;
							state_q   <= ST_FILL_RD;
						end
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_BIN;
				end
				ST_BIN: begin
					if (axis_rsp.done) begin
						cell_q[axis_q] <= axis_rsp.idx;
						if (axis_q == 2'd2) begin
							state_q <= ST_FILL_RD;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_FILL_RD: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (is_insert_q) begin
						if (cell_full) begin
							res_slot_q   <= '0;
							res_label_q  <= '0;
							res_count_q  <= fill_rdata;
							res_status_q <= clb_pkg::STAT_OVERFLOW;
						end else begin
							res_slot_q   <= fill_rdata[clb_pkg::SLOT_W-1:0];
							res_label_q  <= label_q;
							res_count_q  <= fill_wdata;
							res_status_q <= clb_pkg::STAT_OK;
						end
						state_q <= ST_DONE;
					end else begin
						res_count_q <= fill_rdata;
						if (slot_hit) begin
							res_status_q <= clb_pkg::STAT_OK;
							state_q      <= ST_SLOT_WAIT;
						end else begin
							res_label_q  <= '0;
							res_status_q <= clb_pkg::STAT_EMPTY;
							state_q      <= ST_DONE;
						end
					end
				end
				ST_SLOT_WAIT: begin
					res_label_q <= slot_rdata;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					// Hand the result over once the output register is free.
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q           <= 1'b1;
						m_tdata_q.pad        <= 1'b0;
						m_tdata_q.cell_a     <= cell_q[0];
						m_tdata_q.cell_b     <= cell_q[1];
						m_tdata_q.cell_c     <= cell_q[2];
						m_tdata_q.slot       <= res_slot_q;
						m_tdata_q.label_out  <= res_label_q;
						m_tdata_q.cell_count <= res_count_q;
						m_tuser_q            <= res_status_q;
						clr_item_q           <= 1'b0;
						state_q              <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

/* dv/tb_cell_list_binning_unit.sv */
// Self-checking testbench for cell_list_binning_unit: insert, read and clear traffic.
// Uses a local predictor of the binning and slot store to check every output transfer.
// Depends on clb_pkg and cell_list_binning_unit.
`timescale 1ns / 1ps

module tb_cell_list_binning_unit;

	// Clear is selected by bit 1 of the action, so both upper codes clear.
	localparam logic [1:0] ACT_CLEAR     = 2'b10;
	localparam logic [1:0] ACT_CLEAR_ALT = 2'b11;

	localparam logic signed [clb_pkg::FRAC_W-1:0] FRAC_MAX = 19'sh3FFFF;
	localparam logic signed [clb_pkg::FRAC_W-1:0] FRAC_MIN = 19'sh40000;
	localparam logic signed [clb_pkg::FRAC_W-1:0] FRAC_NEG_LSB = -19'sd1;
	localparam logic signed [clb_pkg::FRAC_W-1:0] FRAC_CELL16 = 19'sd4096;

	localparam int NUM_FIELDS = 7;
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [1:0]       action;
		clb_pkg::clb_in_t data;
	} bin_req_t;

	typedef struct packed {
		logic [1:0]        status;
		clb_pkg::clb_out_t data;
	} bin_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = clb_pkg::REG_CELLS_A;
	logic [5:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = clb_pkg::ACT_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// Predictor copy of the grid settings and of the cell storage.
	logic [4:0]                  grid_a = 5'd1;
	logic [4:0]                  grid_b = 5'd1;
	logic [4:0]                  grid_c = 5'd1;
	logic [5:0]                  slot_cap = 6'd32;
	logic [clb_pkg::COUNT_W-1:0] cell_fill [clb_pkg::NUM_CELLS] = '{default: '0};
	logic [clb_pkg::LABEL_W-1:0] label_store [int];

	bin_req_t                      pending_reqs[$];
	bin_result_t                   expected_bins[$];
	logic [clb_pkg::CELL_ID_W-1:0] recent_cells[$];
	bin_req_t                      cur_req;

	int send_gap = 0;
	int stall_left = 0;
	int error_count = 0;
	int accepted_count = 0;
	int phase_no = 0;
	int status_seen [4] = '{default: 0};
	bit calm = 1'b0;
	bit rx_hold = 1'b0;

	string field_names [NUM_FIELDS] = '{"cell_a", "cell_b", "cell_c", "slot", "label_out",
		"cell_count", "status"};

	cell_list_binning_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Generous ceiling: covers the clearing passes, the long hold-off and all stalls.
	initial begin
		#5_000_000;
		$display("tb_cell_list_binning_unit: FAIL");
		$finish;
	end

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Effective cell count of one axis; out-of-range settings saturate.
	function automatic int unsigned axis_cells(logic [4:0] setting);
		if (setting == 0)
			return 1;
		if (setting > clb_pkg::CELLS_PER_AXIS)
			return clb_pkg::CELLS_PER_AXIS;
		return setting;
	endfunction

	function automatic int unsigned fill_limit();
		if (slot_cap == 0)
			return 1;
		if (slot_cap > clb_pkg::SLOTS_PER_CELL)
			return clb_pkg::SLOTS_PER_CELL;
		return slot_cap;
	endfunction

	// floor(frac * n) wrapped into [0, n) by floored modulo.
	function automatic logic [clb_pkg::CELL_W-1:0] bin_coord(
		logic signed [clb_pkg::FRAC_W-1:0] frac, int unsigned n);
		longint nn;
		longint q;
		longint r;
		nn = n;
		q = (longint'(frac) * nn) >>> clb_pkg::FRAC_BITS;
		r = q % nn;
		if (r < 0)
			r = r + nn;
		return r[clb_pkg::CELL_W-1:0];
	endfunction

	// Applies one accepted item to the predictor state and returns its result.
	function automatic bin_result_t predict_binning(bin_req_t req);
		bin_result_t res;
		logic [clb_pkg::CELL_ID_W-1:0] id;
		int unsigned fill;
		res = '0;
		if (req.action[clb_pkg::ACT_CLEAR_BIT]) begin
			foreach (cell_fill[i])
				cell_fill[i] = '0;
			res.status = clb_pkg::STAT_CLEARED;
		end else if (req.action == clb_pkg::ACT_INSERT) begin
			res.data.cell_a = bin_coord(req.data.frac_a, axis_cells(grid_a));
			res.data.cell_b = bin_coord(req.data.frac_b, axis_cells(grid_b));
			res.data.cell_c = bin_coord(req.data.frac_c, axis_cells(grid_c));
			id = {res.data.cell_a, res.data.cell_b, res.data.cell_c};
			fill = cell_fill[id];
			if (fill >= fill_limit()) begin
				res.status = clb_pkg::STAT_OVERFLOW;
				res.data.cell_count = fill[clb_pkg::COUNT_W-1:0];
			end else begin
				res.status = clb_pkg::STAT_OK;
				res.data.slot = fill[clb_pkg::SLOT_W-1:0];
				res.data.label_out = req.data.atom_label;
				label_store[int'({id, res.data.slot})] = req.data.atom_label;
				fill = fill + 1;
				cell_fill[id] = fill[clb_pkg::COUNT_W-1:0];
				res.data.cell_count = fill[clb_pkg::COUNT_W-1:0];
			end
		end else begin
			res.data.cell_a = req.data.read_cell_a;
			res.data.cell_b = req.data.read_cell_b;
			res.data.cell_c = req.data.read_cell_c;
			res.data.slot = req.data.read_slot;
			id = {req.data.read_cell_a, req.data.read_cell_b, req.data.read_cell_c};
			fill = cell_fill[id];
			res.data.cell_count = fill[clb_pkg::COUNT_W-1:0];
			if (req.data.read_slot < fill) begin
				res.status = clb_pkg::STAT_OK;
				res.data.label_out = label_store[int'({id, req.data.read_slot})];
			end else begin
				res.status = clb_pkg::STAT_EMPTY;
			end
		end
		return res;
	endfunction

	function automatic void push_req(logic [1:0] act, logic [clb_pkg::LABEL_W-1:0] lbl,
		logic signed [clb_pkg::FRAC_W-1:0] fa, logic signed [clb_pkg::FRAC_W-1:0] fb,
		logic signed [clb_pkg::FRAC_W-1:0] fc, logic [clb_pkg::CELL_W-1:0] ra,
		logic [clb_pkg::CELL_W-1:0] rb, logic [clb_pkg::CELL_W-1:0] rc,
		logic [clb_pkg::SLOT_W-1:0] rs);
		bin_req_t req;
		req = '0;
		req.action = act;
		req.data.atom_label = lbl;
		req.data.frac_a = fa;
		req.data.frac_b = fb;
		req.data.frac_c = fc;
		req.data.read_cell_a = ra;
		req.data.read_cell_b = rb;
		req.data.read_cell_c = rc;
		req.data.read_slot = rs;
		pending_reqs = {pending_reqs, req};
	endfunction

	// Mostly inside the box, with wrapped, extreme and fully random coordinates mixed in.
	function automatic logic signed [clb_pkg::FRAC_W-1:0] random_frac();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return clb_pkg::FRAC_W'($urandom_range(0, 65535));
			6: return clb_pkg::FRAC_W'($urandom);
			7: begin
				case ($urandom_range(0, 3))
					0: return FRAC_MIN;
					1: return FRAC_MAX;
					2: return FRAC_NEG_LSB;
					default: return 19'sd65536;
				endcase
			end
			default: return clb_pkg::FRAC_W'(int'($urandom_range(0, 131071)) - 65536);
		endcase
	endfunction

	// Random item; reads mostly target cells that recent inserts went to.
	function automatic bin_req_t random_req(int unsigned insert_pct);
		bin_req_t req;
		int unsigned roll;
		int unsigned top_slot;
		logic [clb_pkg::CELL_ID_W-1:0] id;
		req.data = {$urandom, $urandom, $urandom};
		req.data.pad = '0;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			req.action = $urandom_range(0, 1) ? ACT_CLEAR : ACT_CLEAR_ALT;
		end else if (roll < 2 + insert_pct) begin
			req.action = clb_pkg::ACT_INSERT;
			req.data.frac_a = random_frac();
			req.data.frac_b = random_frac();
			req.data.frac_c = random_frac();
			id = {bin_coord(req.data.frac_a, axis_cells(grid_a)),
				bin_coord(req.data.frac_b, axis_cells(grid_b)),
				bin_coord(req.data.frac_c, axis_cells(grid_c))};
			recent_cells = {recent_cells, id};
			if (recent_cells.size() > 32)
				void'(recent_cells.pop_front());
		end else begin
			req.action = clb_pkg::ACT_READ;
			if (recent_cells.size() > 0 && $urandom_range(0, 4) != 0) begin
				id = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
				{req.data.read_cell_a, req.data.read_cell_b, req.data.read_cell_c} = id;
				top_slot = (fill_limit() < clb_pkg::SLOTS_PER_CELL) ? fill_limit()
					: clb_pkg::SLOTS_PER_CELL - 1;
				req.data.read_slot = clb_pkg::SLOT_W'($urandom_range(0, top_slot));
			end
		end
		return req;
	endfunction

	// Writes all four registers on successive edges; only called while the block is idle.
	task automatic program_grid(logic [5:0] va, logic [5:0] vb, logic [5:0] vc,
		logic [5:0] vs);
		logic [5:0] vals [4];
		logic [1:0] regs [4];
		vals = '{va, vb, vc, vs};
		regs = '{clb_pkg::REG_CELLS_A, clb_pkg::REG_CELLS_B, clb_pkg::REG_CELLS_C,
			clb_pkg::REG_SLOTS};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= regs[i];
			cfg_wdata <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_a = va[4:0];
		grid_b = vb[4:0];
		grid_c = vc[4:0];
		slot_cap = vs;
		@(negedge clk);
	endtask

	// Every item gives a result, so an empty expectation queue means the block is idle.
	task automatic wait_drained(int unsigned settle);
		while (pending_reqs.size() != 0 || s_tvalid || expected_bins.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Input driver: predicts each accepted transfer and offers the next pending item.
	always @(posedge clk) begin
		bin_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_bins = {expected_bins, predict_binning(cur_req)};
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					cur_req = nxt;
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data;
					s_tuser <= nxt.action;
					if (!calm && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		clb_pkg::clb_out_t got;
		bin_result_t want;
		logic [clb_pkg::LABEL_W-1:0] got_f [NUM_FIELDS];
		logic [clb_pkg::LABEL_W-1:0] want_f [NUM_FIELDS];
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_bins.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, status %0d",
						m_tuser));
				end else begin
					want = expected_bins.pop_front();
					got_f = '{got.cell_a, got.cell_b, got.cell_c, got.slot, got.label_out,
						got.cell_count, m_tuser};
					want_f = '{want.data.cell_a, want.data.cell_b, want.data.cell_c,
						want.data.slot, want.data.label_out, want.data.cell_count,
						want.status};
					for (int i = 0; i < NUM_FIELDS; i++)
						if (got_f[i] !== want_f[i])
							report_mismatch($sformatf("%s: got %0h, expected %0h",
								field_names[i], got_f[i], want_f[i]));
					status_seen[want.status]++;
				end
			end
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off during the sparse-grid phase so the input backs up.
	initial begin
		wait (phase_no == 3);
		repeat (40) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset grid of one cell with 32 slots: extremes land in cell zero.
		push_req(clb_pkg::ACT_INSERT, 16'hFFFF, FRAC_MAX, FRAC_MAX, FRAC_MAX, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_INSERT, 16'h0000, FRAC_MIN, FRAC_MIN, FRAC_MIN, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 5'd0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 5'd1);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 5'd2);
		// Read outside the configured grid.
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd15, 4'd15, 4'd15, 5'd31);
		wait_drained(8);

		// Out-of-range settings: counts of 0 and 31 and a slot limit of 0.
		program_grid(6'd0, 6'd31, 6'd16, 6'd0);
		push_req(clb_pkg::ACT_INSERT, 16'h1234, FRAC_NEG_LSB, FRAC_NEG_LSB, 0, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_INSERT, 16'hABCD, 0, FRAC_NEG_LSB, 0, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_INSERT, 16'h5A5A, 0, FRAC_CELL16, FRAC_CELL16 - 19'sd1,
			0, 0, 0, 0);
		push_req(clb_pkg::ACT_INSERT, 16'hA5A5, FRAC_MAX, FRAC_MAX, FRAC_MAX, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd15, 4'd0, 5'd0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd1, 4'd0, 5'd1);
		push_req(ACT_CLEAR, 16'h0, 0, 0, 0, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd15, 4'd0, 5'd0);
		push_req(clb_pkg::ACT_INSERT, 16'h0F0F, 0, 0, 0, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 5'd0);
		push_req(ACT_CLEAR_ALT, 16'h0, 0, 0, 0, 0, 0, 0, 0);
		push_req(clb_pkg::ACT_READ, 16'h0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 5'd0);
		wait_drained(8);

		// Random phases, each on its own grid setting; the last one runs without idling.
		for (phase_no = 1; phase_no <= 5; phase_no++) begin
			case (phase_no)
				1: program_grid(6'd5, 6'd3, 6'd7, 6'd63);
				2: program_grid(6'd1, 6'd1, 6'd1, 6'd32);
				3: program_grid(6'd16, 6'd16, 6'd16, 6'd32);
				4: program_grid(6'd2, 6'd2, 6'd2, 6'd4);
				default: begin
					calm = 1'b1;
					program_grid(6'($urandom_range(0, 31)), 6'($urandom_range(0, 31)),
						6'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
				end
			endcase
			recent_cells.delete();
			repeat (80) pending_reqs = {pending_reqs, random_req(phase_no == 2 ? 70 : 55)};
			wait_drained(8);
		end

		repeat (60) @(posedge clk);
		if (expected_bins.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_bins.size()));
		$display("Covered %0d items over seven grid settings, with a long output hold-off.",
			accepted_count);
		$display("Results: %0d ok, %0d overflow, %0d empty slot, %0d cleared; %0d mismatches.",
			status_seen[clb_pkg::STAT_OK], status_seen[clb_pkg::STAT_OVERFLOW],
			status_seen[clb_pkg::STAT_EMPTY], status_seen[clb_pkg::STAT_CLEARED],
			error_count);
		if (error_count == 0)
			$display("tb_cell_list_binning_unit: PASS");
		else
			$display("tb_cell_list_binning_unit: FAIL");
		$finish;
	end

endmodule
